>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the checked modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

>>> hw/rtl/mll_pkg.sv
// Package with the constants, types and alpha function of the moire lightness unit.
package mll_pkg;

	localparam int LAYERS    = 4;
	localparam int REG_COUNT = 4;
	localparam int CFG_IDX_W = $clog2(REG_COUNT);
	localparam int CFG_W     = 64;
	// Four lane stages, then one multiply stage per layer.
	localparam int LATENCY   = 4 + LAYERS;

	localparam logic [15:0] PH_A    = 16'd12288;
	localparam logic [15:0] PH_B    = 16'd20480;
	localparam logic [15:0] PH_C    = 16'd45056;
	localparam logic [15:0] PH_D    = 16'd53248;
	localparam logic [15:0] ONE_Q15 = 16'd32768;

	typedef struct packed {
		logic        [15:0] inv_period;
		logic signed [15:0] offset;
		logic signed [15:0] dir_y;
		logic signed [15:0] dir_x;
	} layer_cfg_t;

	// Trapezoid map from Q0.16 phase to Q1.15 alpha.
	function automatic logic [15:0] phase_to_alpha(input logic [15:0] p);
		logic [15:0] r;
		if (p < PH_A) begin
			r = ONE_Q15;
		end else if (p < PH_B) begin
			r = 16'(ONE_Q15 - ((p - PH_A) << 2));
		end else if (p < PH_C) begin
			r = 16'd0;
		end else if (p < PH_D) begin
			r = 16'((p - PH_C) << 2);
		end else begin
			r = ONE_Q15;
		end
		return r;
	endfunction

endpackage

>>> hw/rtl/mll_layer_phase.sv
// One grating layer lane: projection, magnitude, phase scaling and alpha lookup.
module mll_layer_phase import mll_pkg::*; (
	input  logic               clk,
	input  layer_cfg_t         cfg,
	input  logic signed [15:0] coord_x,
	input  logic signed [15:0] coord_y,
	output logic        [15:0] alpha
);

	logic signed [31:0] prod_x_s1, prod_y_s1;
	logic        [31:0] mag_s2;
	logic        [15:0] phase_s3;
	logic        [15:0] alpha_s4;

	logic [32:0] sum;
	logic [32:0] neg_sum;
	logic [47:0] scaled;

	// Sign-extend both products and the offset (moved to Q.28) to 33 bits.
	always_comb begin
		sum = {prod_x_s1[31], prod_x_s1} + {prod_y_s1[31], prod_y_s1}
			+ {{3{cfg.offset[15]}}, cfg.offset, 14'd0};
		neg_sum = 33'd0 - sum;
		scaled = 48'(mag_s2) * 48'(cfg.inv_period);
	end

	always_ff @(posedge clk) begin
		prod_x_s1 <= coord_x * cfg.dir_x;
		prod_y_s1 <= coord_y * cfg.dir_y;
		mag_s2    <= sum[32] ? neg_sum[31:0] : sum[31:0];
		// Fractional part of the Q.39 product, truncated to 16 bits.
		phase_s3  <= scaled[38:23];
		alpha_s4  <= phase_to_alpha(phase_s3);
	end

	assign alpha = alpha_s4;

endmodule

>>> hw/rtl/mll_product_chain.sv
// Pipelined running product of the layer alphas, one multiply stage per layer.
module mll_product_chain import mll_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        valid_in,
	input  logic [15:0] alpha_in [LAYERS],
	output logic        valid_out,
	output logic [15:0] product
);

	logic [15:0] acc_s   [LAYERS];
	logic [15:0] alpha_s [LAYERS][LAYERS];
	logic        vld_s   [LAYERS];

	for (genvar k = 0; k < LAYERS; k++) begin : g_stage
		logic [15:0] acc_in;
		logic [15:0] al_in [LAYERS];
		logic        v_in;
		logic [31:0] prod;

		if (k == 0) begin : g_first
			assign acc_in = ONE_Q15;
			assign al_in  = alpha_in;
			assign v_in   = valid_in;
		end else begin : g_next
			assign acc_in = acc_s[k-1];
			assign al_in  = alpha_s[k-1];
			assign v_in   = vld_s[k-1];
		end

		assign prod = 32'(acc_in) * 32'(al_in[k]);

		always_ff @(posedge clk) begin
			acc_s[k]   <= prod[30:15];
			alpha_s[k] <= al_in;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else begin
				vld_s[k] <= v_in;
			end
		end
	end

	assign valid_out = vld_s[LAYERS-1];
	assign product   = acc_s[LAYERS-1];

endmodule

>>> hw/rtl/moire_layer_lightness_unit.sv
// Top level of the moire layer lightness unit: configuration registers, lanes and product chain.
//
// The unit takes one pixel coordinate per clock and returns its lightness, the
// product of the alphas of LAYERS grating layers, in Q1.15 with 32768 meaning
// 1.0. A transaction is taken at each rising edge with start high; busy is
// always low, so a new coordinate may follow every cycle. Each result appears
// on lightness with done high for exactly one cycle, in the order the
// coordinates came in. The receiver cannot stall the unit, so results must be
// captured on the cycle done is high. The pipeline holds four lane stages (the
// two projection multiplies, the offset add and magnitude, the inverse-period
// multiply, the trapezoid lookup) followed by one multiply stage per layer in
// the running product. Layer parameters are written through cfg_we, cfg_index
// and cfg_data, one 64-bit register per layer, and take effect at once; they
// must only be changed while no transaction is in flight. The configuration
// registers and valid bits reset to zero; zero parameters make every layer
// transparent and each lightness 1.0.
module moire_layer_lightness_unit import mll_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic signed [15:0]   coord_x,
	input  logic signed [15:0]   coord_y,
	output logic                 done,
	output logic        [15:0]   lightness,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	`include "assert_macros.svh"

	logic [CFG_W-1:0] layer_q [REG_COUNT];
	logic             vld_s1, vld_s2, vld_s3, vld_s4;
	logic [15:0]      alpha_s4 [LAYERS];
	logic             accept;

	// The pipeline never stalls, so a transaction is accepted whenever start is high.
	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < REG_COUNT; i++) begin
				layer_q[i] <= '0;
			end
		end else if (cfg_we) begin
			layer_q[cfg_index] <= cfg_data;
		end
	end

	// Valid bits that accompany the lane stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= accept;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	// One lane per layer. Layers without a register see all-zero parameters,
	// which gives a zero phase and therefore an alpha of 1.0.
	for (genvar i = 0; i < LAYERS; i++) begin : g_lane
		layer_cfg_t lane_cfg;

		if (i < REG_COUNT) begin : g_reg
			assign lane_cfg = layer_cfg_t'(layer_q[i]);
		end else begin : g_none
			assign lane_cfg = '0;
		end

		mll_layer_phase u_lane (
			.clk     (clk),
			.cfg     (lane_cfg),
			.coord_x (coord_x),
			.coord_y (coord_y),
			.alpha   (alpha_s4[i])
		);
	end

	mll_product_chain u_chain (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_in  (vld_s4),
		.alpha_in  (alpha_s4),
		.valid_out (done),
		.product   (lightness)
	);

	// Every accepted transaction produces its result after the fixed latency.
	`ASSERT_IMPLIES(a_result_follows, clk, arst_n, accept, ##LATENCY done)
	// No result appears without a transaction that fed it.
	`ASSERT_IMPLIES(a_no_spurious, clk, arst_n, done, $past(accept, LATENCY))
	// The running product never exceeds 1.0.
	`ASSERT_IMPLIES(a_saturated, clk, arst_n, done, lightness <= ONE_Q15)

endmodule

>>> test/testbench.sv
// Self-checking testbench for the moire layer lightness unit.
module testbench import mll_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	// Register indexes of the four layer parameter words.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LAYER_ZERO,
		REG_LAYER_ONE,
		REG_LAYER_TWO,
		REG_LAYER_THREE
	} layer_reg_e;

	// What the feed queue can ask of the driver: send a pixel, write a layer
	// register, wait until the unit has gone quiet, or change the sender gap rate.
	typedef enum logic [1:0] {
		FEED_PIXEL,
		FEED_WRITE,
		FEED_PAUSE,
		FEED_IDLE
	} feed_kind_e;

	typedef struct {
		feed_kind_e               kind;
		logic signed [15:0]       x;
		logic signed [15:0]       y;
		logic [CFG_IDX_W-1:0]     index;
		logic [CFG_W-1:0]         data;
		int                       idle_pct;
	} feed_step_t;

	// One pixel in flight and the lightness it must come back with.
	typedef struct {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic        [15:0] lightness;
	} lit_pixel_t;

	// Knees of the trapezoid on the Q0.16 phase axis: 3/16, 5/16, 11/16, 13/16.
	localparam int unsigned KNEE_FALL_START = 12288;
	localparam int unsigned KNEE_FALL_END   = 20480;
	localparam int unsigned KNEE_RISE_START = 45056;
	localparam int unsigned KNEE_RISE_END   = 53248;
	localparam int unsigned FULL_ALPHA      = 32768;

	// Cycles to let pass after the last result before the unit counts as idle.
	localparam int SETTLE_CYCLES = LATENCY + 2;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic                 busy;
	logic signed [15:0]   coord_x = '0;
	logic signed [15:0]   coord_y = '0;
	logic                 done;
	logic        [15:0]   lightness;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;

	feed_step_t feed_steps[$];
	lit_pixel_t pending_pixels[$];
	layer_cfg_t layer_shadow[REG_COUNT] = '{default: '0};
	int         mismatch_count = 0;

	moire_layer_lightness_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.coord_x   (coord_x),
		.coord_y   (coord_y),
		.done      (done),
		.lightness (lightness),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// Lightness of one pixel under the shadow copy of the layer registers.
	// Each layer projects the point on its direction, adds its offset (scaled
	// from Q.14 to Q.28), takes the magnitude and multiplies by the inverse
	// period; bits 38:23 of that Q.39 product are the Q0.16 phase. The phase
	// goes through the trapezoid and the alphas are chained as a Q1.15 product
	// that is truncated after every layer.
	function automatic logic [15:0] predict_lightness(logic signed [15:0] x,
							  logic signed [15:0] y);
		longint            proj;
		longint unsigned   mag;
		longint unsigned   scaled;
		int unsigned       phase;
		int unsigned       alpha;
		longint unsigned   product;
		layer_cfg_t        layer;
		product = FULL_ALPHA;
		for (int i = 0; i < LAYERS; i++) begin
			// Layers without a register are transparent.
			alpha = FULL_ALPHA;
			if (i < REG_COUNT) begin
				layer = layer_shadow[i];
				proj = longint'(x) * longint'($signed(layer.dir_x))
				     + longint'(y) * longint'($signed(layer.dir_y))
				     + longint'($signed(layer.offset)) * 16384;
				mag = (proj < 0) ? longint'(-proj) : longint'(proj);
				scaled = mag * longint'({48'd0, layer.inv_period});
				phase = int'(scaled[38:23]);
				if (phase < KNEE_FALL_START) begin
					alpha = FULL_ALPHA;
				end else if (phase < KNEE_FALL_END) begin
					alpha = FULL_ALPHA - 4 * (phase - KNEE_FALL_START);
				end else if (phase < KNEE_RISE_START) begin
					alpha = 0;
				end else if (phase < KNEE_RISE_END) begin
					alpha = 4 * (phase - KNEE_RISE_START);
				end else begin
					alpha = FULL_ALPHA;
				end
			end
			product = (product * alpha) >> 15;
		end
		return product[15:0];
	endfunction

	function automatic void push_pixel(logic signed [15:0] x, logic signed [15:0] y);
		feed_step_t s;
		s = '{kind: FEED_PIXEL, x: x, y: y, index: '0, data: '0, idle_pct: 0};
		feed_steps.push_back(s);
	endfunction

	function automatic void push_write(layer_reg_e index, logic [CFG_W-1:0] data);
		feed_step_t s;
		s = '{kind: FEED_WRITE, x: '0, y: '0, index: index, data: data, idle_pct: 0};
		feed_steps.push_back(s);
	endfunction

	// A pause holds the sender until every expected lightness has come back,
	// so that the registers are only written while the unit is empty.
	function automatic void push_pause();
		feed_step_t s;
		s = '{kind: FEED_PAUSE, x: '0, y: '0, index: '0, data: '0, idle_pct: 0};
		feed_steps.push_back(s);
	endfunction

	function automatic void push_idle(int pct);
		feed_step_t s;
		s = '{kind: FEED_IDLE, x: '0, y: '0, index: '0, data: '0, idle_pct: pct};
		feed_steps.push_back(s);
	endfunction

	// Driver: works through the feed queue one step per cycle when no pause or gap
	// holds it. A pixel stays on the ports until a transaction takes it; start is
	// computed once per cycle so back-to-back pixels keep it high without a glitch.
	always @(posedge clk or negedge arst_n) begin : feed_driver
		logic       next_start;
		logic       next_we;
		int         settle_left;
		int         idle_pct;
		feed_step_t step;
		if (!arst_n) begin
			start     <= 1'b0;
			coord_x   <= '0;
			coord_y   <= '0;
			cfg_we    <= 1'b0;
			cfg_index <= '0;
			cfg_data  <= '0;
			settle_left = 0;
			idle_pct = 0;
		end else begin
			next_start = start && busy;
			next_we = 1'b0;
			if (!next_start) begin
				if (settle_left != 0) begin
					settle_left = settle_left - 1;
				end else if (feed_steps.size() != 0) begin
					step = feed_steps[0];
					case (step.kind)
					FEED_PIXEL: begin
						// Random gaps land on any phase of the pipeline.
						if ($urandom_range(99) >= idle_pct) begin
							next_start = 1'b1;
							coord_x <= step.x;
							coord_y <= step.y;
							void'(feed_steps.pop_front());
						end
					end
					FEED_WRITE: begin
						next_we = 1'b1;
						cfg_index <= step.index;
						cfg_data <= step.data;
						void'(feed_steps.pop_front());
					end
					FEED_PAUSE: begin
						// start low means no transaction was taken at this
						// edge, so an empty queue really means nothing in flight.
						if (!start && pending_pixels.size() == 0) begin
							settle_left = SETTLE_CYCLES;
							void'(feed_steps.pop_front());
						end
					end
					FEED_IDLE: begin
						idle_pct = step.idle_pct;
						void'(feed_steps.pop_front());
					end
					default: begin
						void'(feed_steps.pop_front());
					end
					endcase
				end
			end
			start <= next_start;
			cfg_we <= next_we;
		end
	end

	// Monitor: mirrors register writes, predicts each accepted pixel and checks
	// every result strobe against the oldest prediction. Ports are sampled at
	// the edge, so all values seen here are the ones from before the edge.
	always @(posedge clk) begin : result_monitor
		lit_pixel_t want;
		lit_pixel_t taken;
		if (arst_n) begin
			if (done) begin
				if (pending_pixels.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("unexpected result: lightness %0d", lightness);
				end else begin
					want = pending_pixels.pop_front();
					if (lightness !== want.lightness) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("lightness mismatch at x=%0d y=%0d: expected %0d, got %0d",
								 want.x, want.y, want.lightness, lightness);
					end
				end
			end
			if (cfg_we)
				layer_shadow[cfg_index] = cfg_data;
			if (start && !busy) begin
				taken.x = coord_x;
				taken.y = coord_y;
				taken.lightness = predict_lightness(coord_x, coord_y);
				pending_pixels.push_back(taken);
			end
		end
	end

	// Stimulus plan, reset and end of the run.
	initial begin : stimulus_plan
		logic [CFG_W-1:0] word;
		layer_cfg_t       layer;
		push_idle(33);

		// Registers straight out of reset: every layer is transparent.
		push_pixel(16'sh7FFF, -16'sh8000);
		push_pixel(-16'sh8000, 16'sh7FFF);

		// Layer zero sees x at unit period, so the phase is 4*|x| and walks
		// across every knee of the trapezoid. The other layers carry a zero
		// inverse period and must stay transparent despite their other fields.
		push_pause();
		layer = '{inv_period: 16'd2048, offset: '0, dir_y: '0, dir_x: 16'sh4000};
		push_write(REG_LAYER_ZERO, layer);
		layer = '{inv_period: 16'd0, offset: 16'sh0100, dir_y: -16'sh3000, dir_x: 16'sh1234};
		push_write(REG_LAYER_ONE, layer);
		push_write(REG_LAYER_TWO, layer);
		push_write(REG_LAYER_THREE, layer);
		push_pixel(16'sd0, 16'sd0);
		push_pixel(16'sd3071, 16'sd0);
		push_pixel(16'sd3072, -16'sd1);
		push_pixel(16'sd5119, 16'sd100);
		push_pixel(16'sd5120, 16'sd0);
		push_pixel(16'sd8192, 16'sd0);
		push_pixel(16'sd11263, 16'sd0);
		push_pixel(16'sd11264, 16'sd0);
		push_pixel(16'sd13311, 16'sd0);
		push_pixel(16'sd13312, 16'sd0);
		push_pixel(16'sd16383, 16'sd0);
		push_pixel(-16'sd3072, 16'sd0);
		push_pixel(-16'sh8000, 16'sh7FFF);
		push_pixel(16'sh7FFF, -16'sh8000);

		// The same walk on the y axis with an offset, y at its extremes.
		push_pause();
		layer = '{inv_period: 16'd2048, offset: 16'sh0800, dir_y: 16'sh4000, dir_x: '0};
		push_write(REG_LAYER_ZERO, layer);
		push_pixel(16'sd0, -16'sh8000);
		push_pixel(-16'sd1, 16'sh7FFF);
		push_pixel(16'sh7FFF, 16'sd0);
		push_pixel(16'sd0, 16'sd4000);

		// Every register bit set: directions and offset of minus one, largest
		// inverse period.
		push_pause();
		for (int r = 0; r < REG_COUNT; r++)
			push_write(layer_reg_e'(r), '1);
		push_pixel(-16'sh8000, -16'sh8000);
		push_pixel(16'sh7FFF, 16'sh7FFF);

		// Most negative directions and offset: the largest projection magnitude.
		push_pause();
		layer = '{inv_period: 16'hFFFF, offset: -16'sh8000, dir_y: -16'sh8000,
			  dir_x: -16'sh8000};
		for (int r = 0; r < REG_COUNT; r++)
			push_write(layer_reg_e'(r), layer);
		push_pixel(-16'sh8000, -16'sh8000);
		push_pixel(16'sh7FFF, 16'sh7FFF);

		// Random part: six layer settings, the sender gap rate stepping from
		// 33 to 81 percent and then to none.
		for (int k = 0; k < 6; k++) begin
			if (k == 2)
				push_idle(81);
			if (k == 4)
				push_idle(0);
			push_pause();
			for (int r = 0; r < REG_COUNT; r++) begin
				word = {$urandom, $urandom};
				// Transparent layers keep the product away from zero often
				// enough; small inverse periods give smooth ramps.
				case ($urandom_range(3))
				0: word[63:48] = '0;
				1: word[63:48] = 16'($urandom_range(4095));
				default: ;
				endcase
				push_write(layer_reg_e'(r), word);
			end
			for (int n = 0; n < 87; n++)
				push_pixel(16'($urandom), 16'($urandom));
		end

		// Back to all zero through the write port.
		push_pause();
		for (int r = 0; r < REG_COUNT; r++)
			push_write(layer_reg_e'(r), '0);
		for (int n = 0; n < 6; n++)
			push_pixel(16'($urandom), 16'($urandom));

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		while (feed_steps.size() != 0 || start || pending_pixels.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (mismatch_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	// Watchdog: fails the run if it does not finish in time.
	initial begin : watchdog
		#2_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule

>>> moire_layer_lightness_unit.f
+incdir+hw/rtl
hw/rtl/mll_pkg.sv
hw/rtl/mll_layer_phase.sv
hw/rtl/mll_product_chain.sv
hw/rtl/moire_layer_lightness_unit.sv
test/testbench.sv
